/* design/feedback_delay_mix_core_defines.svh */
// assertion macros used by the checker file
`ifndef FEEDBACK_DELAY_MIX_CORE_DEFINES_SVH
`define FEEDBACK_DELAY_MIX_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define FDM_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define FDM_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/fdm_pkg.sv */
// shared types and constants of the feedback delay mix block
package fdm_pkg;

  localparam int MAX_DELAY_DEF    = 131072;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int LEN_FIELD_W = 18;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 17;

  localparam int FB_FRAC  = 16;
  localparam int MIX_FRAC = 15;

  localparam int LEN_RESET = 14400;
  localparam logic [GAIN_W-1:0] FB_RESET  = 16'd19661;
  localparam logic [GAIN_W-1:0] MIX_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0] FB_LIMIT  = 16'd58982;
  localparam logic [COEF_W-1:0] MIX_ONE   = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_MIX       = 2'd2
  } fdm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WET,
    S_MIX,
    S_DONE
  } fdm_state_t;

  // en: load the accumulator this cycle, acc: add the product instead of replacing
  typedef struct packed {
    logic en;
    logic acc;
  } fdm_mac_op_t;

endpackage

/* design/fdm_if.sv */
// request channel interfaces: sample in, sample out and register writes
interface fdm_in_if #(
  parameter int SAMPLE_WIDTH = fdm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdm_out_if #(
  parameter int SAMPLE_WIDTH = fdm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fdm_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [fdm_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* design/fdm_mac.sv */
// shared multiply-accumulate unit: sample times unsigned coefficient
module fdm_mac #(
  parameter int SAMPLE_WIDTH = fdm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic signed [SAMPLE_WIDTH-1:0]                    a,
  input  logic [fdm_pkg::COEF_W-1:0]                        b,
  input  fdm_pkg::fdm_mac_op_t                              op,
  output logic signed [SAMPLE_WIDTH+fdm_pkg::COEF_W:0]      acc
);

  localparam int ACC_W = SAMPLE_WIDTH + fdm_pkg::COEF_W + 1;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  assign prod    = a * $signed({1'b0, b});
  assign acc_nxt = op.acc ? acc_r + prod : prod;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* design/feedback_delay_mix_core.sv */
// top level: feedback comb delay with dry/wet mix around one shared multiplier
//
//  channel  | dir | payload                    | handshake
//  ---------+-----+----------------------------+------------------
//  in_bus   | in  | sample_in                  | valid / ready
//  out_bus  | out | sample_out                 | valid / ready
//  cfg_bus  | in  | reg_index, wr_data         | valid / ready (always ready)
//
// each sample passes in turn through accept and memory read, feedback product, write-back with
// the dry product, wet product and output load; they run one after another around the single multiplier.
// the output register lets a new sample in while the last result waits; a stalled
// result holds the sequencer in its last step.
// reset and every delay length write restart the delay line with no clearing pass:
// entries are read as zero until the position first wraps.
module feedback_delay_mix_core #(
  parameter int MAX_DELAY    = fdm_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_WIDTH = fdm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fdm_in_if.sink      in_bus,
  fdm_out_if.source   out_bus,
  fdm_cfg_if.sink     cfg_bus
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ADDR_W = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int ACC_W  = SW + fdm_pkg::COEF_W + 1;
  localparam int EXT_W  = SW + 3;
  localparam int LEN_RST_INT =
    (fdm_pkg::LEN_RESET > MAX_DELAY) ? MAX_DELAY : fdm_pkg::LEN_RESET;
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(LEN_RST_INT);
  localparam logic signed [ACC_W-1:0] FB_HALF  = ACC_W'(2 ** (fdm_pkg::FB_FRAC - 1));
  localparam logic signed [ACC_W-1:0] MIX_HALF = ACC_W'(2 ** (fdm_pkg::MIX_FRAC - 1));

  fdm_pkg::fdm_state_t state_r, state_nxt;

  logic [LEN_W-1:0]                  len_r;
  logic [fdm_pkg::GAIN_W-1:0]        fb_r;
  logic [fdm_pkg::GAIN_W-1:0]        mix_r;
  logic [ADDR_W-1:0]                 pos_r;
  logic                              wrapped_r;
  logic signed [SW-1:0]              x_r;
  logic signed [SW-1:0]              rd_r;
  logic signed [SW-1:0]              wet_r;
  logic signed [SW-1:0]              wet_nxt;
  logic                              out_valid_r;
  logic signed [SW-1:0]              out_data_r;
  logic signed [SW-1:0]              mem [MAX_DELAY];

  logic                              in_acc;
  logic                              load_out;
  logic                              mem_we;
  logic                              bypass;
  logic [LEN_W-1:0]                  pos_inc;
  logic [31:0]                       cfg_len_ext;
  logic [LEN_W-1:0]                  cfg_len;
  logic [fdm_pkg::GAIN_W-1:0]        cfg_v16;

  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           fb_rnd;
  logic signed [ACC_W-1:0]           mix_rnd;
  logic signed [EXT_W-1:0]           wet_sum;
  logic signed [SW-1:0]              mixed;
  logic signed [SW-1:0]              mac_a;
  logic [fdm_pkg::COEF_W-1:0]        mac_b;
  fdm_pkg::fdm_mac_op_t              mac_op;

  function automatic logic [SW-1:0] sat_sample(input logic [EXT_W-1:0] v);
    logic fits;
    fits = (&v[EXT_W-1:SW-1]) || (~|v[EXT_W-1:SW-1]);
    if (fits) begin
      return v[SW-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  fdm_mac #(.SAMPLE_WIDTH(SW)) u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .op  (mac_op),
    .acc (acc)
  );

  assign in_acc = in_bus.valid && in_bus.ready;
  assign bypass = (len_r == '0);

  // wet path: round the feedback product, add the dry sample, clamp; bypass: dry only
  assign fb_rnd  = acc + FB_HALF;
  assign wet_sum = {{3{x_r[SW-1]}}, x_r}
                 + {fb_rnd[ACC_W-1], fb_rnd[ACC_W-1:fdm_pkg::FB_FRAC]};
  assign wet_nxt = bypass ? x_r : sat_sample(wet_sum);

  assign mix_rnd = acc + MIX_HALF;
  assign mixed   = sat_sample(mix_rnd[ACC_W-1:fdm_pkg::MIX_FRAC]);

  assign pos_inc = LEN_W'(pos_r) + LEN_W'(1);

  assign cfg_len_ext = 32'(cfg_bus.wr_data[fdm_pkg::LEN_FIELD_W-1:0]);
  assign cfg_len = (cfg_len_ext > 32'(MAX_DELAY)) ? LEN_W'(MAX_DELAY)
                                                  : LEN_W'(cfg_len_ext);
  assign cfg_v16 = cfg_bus.wr_data[fdm_pkg::GAIN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fdm_pkg::S_IDLE:  if (in_acc) state_nxt = fdm_pkg::S_FETCH;
      fdm_pkg::S_FETCH: state_nxt = fdm_pkg::S_WET;
      fdm_pkg::S_WET:   state_nxt = fdm_pkg::S_MIX;
      fdm_pkg::S_MIX:   state_nxt = fdm_pkg::S_DONE;
      fdm_pkg::S_DONE:  if (load_out) state_nxt = fdm_pkg::S_IDLE;
      default:          state_nxt = fdm_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_bus.ready = 1'b0;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mac_a        = x_r;
    mac_b        = '0;
    mac_op       = '{en: 1'b0, acc: 1'b0};
    unique case (state_r)
      fdm_pkg::S_IDLE: begin
        in_bus.ready = 1'b1;
      end
      fdm_pkg::S_FETCH: begin
        // an entry not yet written since the restart reads as zero
        mac_a  = wrapped_r ? rd_r : '0;
        mac_b  = {1'b0, fb_r};
        mac_op = '{en: 1'b1, acc: 1'b0};
      end
      fdm_pkg::S_WET: begin
        mem_we = !bypass;
        mac_a  = x_r;
        mac_b  = fdm_pkg::MIX_ONE - {1'b0, mix_r};
        mac_op = '{en: 1'b1, acc: 1'b0};
      end
      fdm_pkg::S_MIX: begin
        mac_a  = wet_r;
        mac_b  = {1'b0, mix_r};
        mac_op = '{en: 1'b1, acc: 1'b1};
      end
      fdm_pkg::S_DONE: begin
        load_out = !out_valid_r || out_bus.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // registers, delay position and restart flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RST;
      fb_r      <= fdm_pkg::FB_RESET;
      mix_r     <= fdm_pkg::MIX_RESET;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.reg_index)
          fdm_pkg::REG_DELAY_LENGTH: begin
            len_r     <= cfg_len;
            pos_r     <= '0;
            wrapped_r <= 1'b0;
          end
          fdm_pkg::REG_FEEDBACK_GAIN: begin
            fb_r <= (cfg_v16 > fdm_pkg::FB_LIMIT) ? fdm_pkg::FB_LIMIT : cfg_v16;
          end
          fdm_pkg::REG_WET_MIX: begin
            mix_r <= (cfg_v16 > fdm_pkg::MIX_ONE[fdm_pkg::GAIN_W-1:0] && cfg_v16[15])
                     ? fdm_pkg::MIX_ONE[fdm_pkg::GAIN_W-1:0] : cfg_v16;
          end
          default: begin
          end
        endcase
      end else if (mem_we) begin
        if (pos_inc == len_r) begin
          pos_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          pos_r <= pos_inc[ADDR_W-1:0];
        end
      end
    end
  end

  // delay memory: read at accept, write back in the wet step
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[pos_r];
    end
    if (mem_we) begin
      mem[pos_r] <= wet_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_bus.sample_in;
    end
    if (state_r == fdm_pkg::S_WET) begin
      wet_r <= wet_nxt;
    end
    if (load_out) begin
      out_data_r <= mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.sample_out = out_data_r;
  assign cfg_bus.ready      = 1'b1;

endmodule

/* design/fdm_checker.sv */
// port-level checks on the feedback delay mix top level, bound in below
`include "feedback_delay_mix_core_defines.svh"

module fdm_checker #(
  parameter int SAMPLE_WIDTH = fdm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample
);

  // a sample in work keeps the input closed for the next steps
  `FDM_ASSERT_RUN(a_busy_after_req, clk, rst_n, (in_valid && in_ready) |=> !in_ready ##1 !in_ready, "input open while a sample is in work")

  // no result can appear straight after a request while the output was empty
  `FDM_ASSERT_RUN(a_no_early_out, clk, rst_n, (in_valid && in_ready && !out_valid) |=> !out_valid, "result appeared one cycle after request")

  `FDM_ASSERT_RUN(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)), "stalled result dropped or changed")

  `FDM_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind feedback_delay_mix_core fdm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample_out)
);

/* tb/feedback_delay_mix_core_tb.sv */
// self-checking testbench for the feedback delay mix core
`timescale 1ns / 100ps

module feedback_delay_mix_core_tb;

  typedef logic signed [fdm_pkg::SAMPLE_WIDTH_DEF-1:0] sample_t;
  typedef logic [fdm_pkg::CFG_DATA_W-1:0]              cfg_word_t;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [fdm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint PEAK_POS  = 32767;
  localparam longint PEAK_NEG  = -32768;
  localparam longint ROUND_FB  = longint'(1) << (fdm_pkg::FB_FRAC - 1);
  localparam longint ROUND_MIX = longint'(1) << (fdm_pkg::MIX_FRAC - 1);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on;
  int   fail_count;

  fdm_in_if  in_bus ();
  fdm_out_if out_bus ();
  fdm_cfg_if cfg_bus ();

  feedback_delay_mix_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: register copies, delay line and its write position
  int unsigned                echo_len;
  logic [fdm_pkg::GAIN_W-1:0] fb_gain;
  logic [fdm_pkg::COEF_W-1:0] mix_gain;
  int unsigned                echo_pos;
  sample_t                    echo_mem [int unsigned];
  sample_t                    mix_expected [$];

  function automatic sample_t clamp_sample(longint v);
    if (v > PEAK_POS) return sample_t'(PEAK_POS);
    if (v < PEAK_NEG) return sample_t'(PEAK_NEG);
    return sample_t'(v);
  endfunction

  // entries never written since the last length write read as zero
  function automatic void load_echo_length(cfg_word_t data);
    echo_len = (int'(data) > fdm_pkg::MAX_DELAY_DEF) ? fdm_pkg::MAX_DELAY_DEF : int'(data);
    echo_mem.delete();
    echo_pos = 0;
  endfunction

  function automatic sample_t echo_mix(sample_t x);
    longint wet;
    longint delayed;
    longint acc;
    wet = x;
    if (echo_len != 0) begin
      delayed = echo_mem.exists(echo_pos) ? longint'(echo_mem[echo_pos]) : longint'(0);
      wet = clamp_sample(x + ((longint'(fb_gain) * delayed + ROUND_FB) >>> fdm_pkg::FB_FRAC));
      echo_mem[echo_pos] = sample_t'(wet);
      echo_pos = (echo_pos + 1 == echo_len) ? 0 : echo_pos + 1;
    end
    acc = longint'(x) * (longint'(fdm_pkg::MIX_ONE) - longint'(mix_gain))
        + wet * longint'(mix_gain) + ROUND_MIX;
    return clamp_sample(acc >>> fdm_pkg::MIX_FRAC);
  endfunction

  function automatic cfg_word_t pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cfg_word_t'(fdm_pkg::MAX_DELAY_DEF);
      2: return cfg_word_t'($urandom);
      default: return cfg_word_t'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic cfg_word_t pick_coef(int limit);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return cfg_word_t'(limit);
      2: return cfg_word_t'($urandom);
      default: return cfg_word_t'($urandom_range(0, limit));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(PEAK_POS);
      1: return sample_t'(PEAK_NEG);
      2: return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // valid stays high on return so back-to-back requests need no second assignment
  task automatic send_sample(sample_t x);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    mix_expected.push_back(echo_mix(x));
  endtask

  task automatic write_reg(logic [fdm_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data,
                           bit last_one);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      fdm_pkg::REG_DELAY_LENGTH:  load_echo_length(data);
      fdm_pkg::REG_FEEDBACK_GAIN:
        fb_gain = (data[15:0] > fdm_pkg::FB_LIMIT) ? fdm_pkg::FB_LIMIT : data[15:0];
      fdm_pkg::REG_WET_MIX:
        mix_gain = ({1'b0, data[15:0]} > fdm_pkg::MIX_ONE) ? fdm_pkg::MIX_ONE
                                                           : {1'b0, data[15:0]};
      default: ;
    endcase
    if (last_one) cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset settings: the line is far longer than the run, so output follows input
  task automatic test_reset_state();
    sample_t corner_vals[] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
                               16'shFFFF, 16'sh5555, 16'shAAAA};
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
  endtask

  // one-sample loop with gains written above their limits drives wet into the rails
  task automatic test_feedback_saturation();
    drain_results();
    write_reg(fdm_pkg::REG_DELAY_LENGTH, 18'd1, 1'b0);
    write_reg(fdm_pkg::REG_FEEDBACK_GAIN, 18'h3FFFF, 1'b0);
    write_reg(fdm_pkg::REG_WET_MIX, 18'h1FFFF, 1'b1);
    repeat (3) send_sample(sample_t'(PEAK_POS));
    repeat (3) send_sample(sample_t'(PEAK_NEG));
  endtask

  task automatic test_bypass();
    drain_results();
    write_reg(fdm_pkg::REG_DELAY_LENGTH, 18'd0, 1'b0);
    write_reg(fdm_pkg::REG_WET_MIX, pick_coef(int'(fdm_pkg::MIX_ONE)), 1'b1);
    send_sample(sample_t'(PEAK_POS));
    send_sample(sample_t'(PEAK_NEG));
    send_sample(pick_sample());
  endtask

  // oversized length clamps to the maximum; a write to the spare index changes nothing
  task automatic test_long_line_and_unused_reg();
    drain_results();
    write_reg(fdm_pkg::REG_DELAY_LENGTH, 18'h3FFFF, 1'b0);
    write_reg(REG_UNUSED, cfg_word_t'($urandom), 1'b0);
    write_reg(fdm_pkg::REG_FEEDBACK_GAIN, 18'd0, 1'b0);
    write_reg(fdm_pkg::REG_WET_MIX, 18'd0, 1'b1);
    repeat (3) send_sample(pick_sample());
  endtask

  // gain and mix writes alone must leave the delay line as it is
  task automatic test_random_traffic(int phases, int items, bit with_gaps);
    for (int p = 0; p < phases; p++) begin
      drain_results();
      gaps_on = with_gaps;
      if ($urandom_range(0, 2) != 0)
        write_reg(fdm_pkg::REG_DELAY_LENGTH, pick_length(), 1'b0);
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, cfg_word_t'($urandom), 1'b0);
      write_reg(fdm_pkg::REG_FEEDBACK_GAIN, pick_coef(int'(fdm_pkg::FB_LIMIT)), 1'b0);
      write_reg(fdm_pkg::REG_WET_MIX, pick_coef(int'(fdm_pkg::MIX_ONE)), 1'b1);
      repeat (items) send_sample(pick_sample());
    end
  endtask

  initial begin : sink_ready
    int burst;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_bus.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    sample_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (mix_expected.size() == 0) begin
        $error("sample_out: expected none, actual %0d", out_bus.sample_out);
        fail_count++;
      end else begin
        want = mix_expected.pop_front();
        if (out_bus.sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_bus.sample_out);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** feedback_delay_mix_core: FAILED **");
    $finish;
  end

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.sample_in  <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.reg_index <= fdm_pkg::REG_DELAY_LENGTH;
    cfg_bus.wr_data   <= '0;
    gaps_on    = 1'b1;
    fail_count = 0;
    load_echo_length(cfg_word_t'(fdm_pkg::LEN_RESET));
    fb_gain  = fdm_pkg::FB_RESET;
    mix_gain = {1'b0, fdm_pkg::MIX_RESET};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_feedback_saturation();
    test_bypass();
    test_long_line_and_unused_reg();
    test_random_traffic(22, 45, 1'b1);
    test_random_traffic(2, 70, 1'b0);
    drain_results();

    if (fail_count == 0 && mix_expected.size() == 0) begin
      $display("** feedback_delay_mix_core: PASSED **");
    end else begin
      $display("** feedback_delay_mix_core: FAILED **");
    end
    $finish;
  end

endmodule

/* feedback_delay_mix_core.f */
+incdir+design
design/fdm_pkg.sv
design/fdm_if.sv
design/fdm_mac.sv
design/feedback_delay_mix_core.sv
design/fdm_checker.sv
tb/feedback_delay_mix_core_tb.sv
